[sv/lwpd_pkg.sv]
// ----------------------------------------------------------------------------
// lwpd_pkg: shared types and constants of the landmark weighted distance unit
// Command and status bundles between controller and datapath, operation and
// register codes, and the per-landmark radius and weight tables.
// ----------------------------------------------------------------------------
`default_nettype none

package lwpd_pkg;

  // default parameter values
  localparam int COORD_BITS_DEF = 24;
  localparam int FRAC_BITS_DEF  = 8;
  localparam int COUNT_BITS_DEF = 16;

  // fixed widths
  localparam int NUM_MARKS = 6;
  localparam int SLOT_W    = 3;
  localparam int TOTAL_W   = 63;
  localparam int WEIGHT_W  = 9;
  localparam int BASE_W    = 8;
  localparam int TUSER_W   = 4;

  // landmark slots of the nose and the jaw
  localparam logic [SLOT_W-1:0] SLOT_NOSE = 3'd2;
  localparam logic [SLOT_W-1:0] SLOT_JAW  = 3'd5;

  // operation codes
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_PAIR = 1'b1;

  // configuration register indexes
  localparam logic CFG_MODE = 1'b0;
  localparam logic CFG_BASE = 1'b1;

  // axis select for the squared distance
  typedef enum logic [1:0] {
    AXIS_X,
    AXIS_Y,
    AXIS_Z
  } axis_t;

  // controller to datapath
  typedef struct packed {
    logic              sq_acc;
    axis_t             axis;
    logic              root_init;
    logic              root_step;
    logic              hold;
    logic              load_direct;
    logic              load_held;
    logic              w_a;
    logic              w_b;
    logic              w_c;
    logic              prod;
    logic              add;
    logic              emit;
    logic [SLOT_W-1:0] idx;
    logic [SLOT_W-1:0] lm;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic mode;
    logic last;
    logic out_free;
  } status_t;

  // radius of a landmark in whole units
  function automatic logic [3:0] mark_radius(input logic [SLOT_W-1:0] slot,
                                             input logic self_rule);
    logic [3:0] r;
    case (slot)
      3'd0, 3'd1: r = self_rule ? 4'd8 : 4'd5;
      3'd2:       r = 4'd5;
      3'd3, 3'd4: r = self_rule ? 4'd3 : 4'd4;
      default:    r = 4'd2;
    endcase
    return r;
  endfunction

  // weight added in halves when a landmark is hit
  function automatic logic [2:0] mark_bonus(input logic [SLOT_W-1:0] slot);
    logic [2:0] b;
    case (slot)
      3'd0, 3'd1: b = 3'd6;
      3'd2:       b = 3'd4;
      3'd3, 3'd4: b = 3'd2;
      default:    b = 3'd1;
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

[sv/landmark_weighted_point_distance_unit.sv]
// ----------------------------------------------------------------------------
// landmark_weighted_point_distance_unit: weighted 3D point distance summer
// Stream front end around the sequencer and datapath of the unit.
// ----------------------------------------------------------------------------
// A landmark load transfer is taken in the idle state and starts no sequence.
// A point pair keeps the input busy after its transfer: squaring of the
// three axes, start and steps of the bit-serial square root, placing of the
// pair, six landmark radius tests, each through steps WA, WB and WC, on one
// shared test unit, weighting and accumulation (PROD, ADD) and a check for
// the last pair. The next transfer is taken only once the unit is back in
// idle, so a new pair is not accepted before the last one is through. A
// self-mode pair that is only held skips the tests. The pair that completes
// the landmark set also replays the six held pairs through the radius tests
// and accumulator; a last pair with an incomplete set replays what is held in
// the same way. A last pair then hands its total to the output register,
// waiting while an earlier total still waits there. Configuration writes are
// taken only while no pair is in flight, ahead of an input transfer offered
// in the same cycle.
`default_nettype none

module landmark_weighted_point_distance_unit #(
  parameter int COORD_BITS = lwpd_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS  = lwpd_pkg::FRAC_BITS_DEF,
  parameter int COUNT_BITS = lwpd_pkg::COUNT_BITS_DEF,
  localparam int IN_DW  = ((6 * COORD_BITS + 7) / 8) * 8,
  localparam int OUT_DW = ((lwpd_pkg::TOTAL_W + COUNT_BITS + 7) / 8) * 8
) (
  input  wire                          clk,
  input  wire                          rst_n,
  // src_x, src_y, src_z, tgt_x, tgt_y, tgt_z
  input  wire  [IN_DW-1:0]             in_tdata,
  // operation, landmark_slot
  input  wire  [lwpd_pkg::TUSER_W-1:0] in_tuser,
  input  wire                          in_tlast,
  input  wire                          in_tvalid,
  output logic                         in_tready,
  // total_distance, pairs_counted
  output logic [OUT_DW-1:0]            out_tdata,
  output logic                         out_tvalid,
  input  wire                          out_tready,
  input  wire                          cfg_valid,
  output logic                         cfg_ready,
  input  wire                          cfg_index,
  input  wire  [lwpd_pkg::BASE_W-1:0]  cfg_data
);

  logic                          in_fire;
  logic                          cfg_fire;
  logic                          idle;
  lwpd_pkg::cmd_t                cmd;
  lwpd_pkg::status_t             status;
  logic [lwpd_pkg::TOTAL_W-1:0]  out_total;
  logic [COUNT_BITS-1:0]         out_count;

  // configuration only while idle, ahead of an input transfer
  assign cfg_ready = idle;
  assign cfg_fire  = cfg_valid && cfg_ready;
  assign in_tready = idle && !cfg_valid;
  assign in_fire   = in_tvalid && in_tready;

  lwpd_ctrl #(
    .COORD_BITS (COORD_BITS)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_fire  (in_fire),
    .in_op    (in_tuser[0]),
    .in_ready (idle),
    .status   (status),
    .cmd      (cmd)
  );

  lwpd_dp #(
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_fire   (in_fire),
    .in_op     (in_tuser[0]),
    .in_slot   (in_tuser[3:1]),
    .in_src_x  (in_tdata[0*COORD_BITS +: COORD_BITS]),
    .in_src_y  (in_tdata[1*COORD_BITS +: COORD_BITS]),
    .in_src_z  (in_tdata[2*COORD_BITS +: COORD_BITS]),
    .in_tgt_x  (in_tdata[3*COORD_BITS +: COORD_BITS]),
    .in_tgt_y  (in_tdata[4*COORD_BITS +: COORD_BITS]),
    .in_tgt_z  (in_tdata[5*COORD_BITS +: COORD_BITS]),
    .in_last   (in_tlast),
    .cfg_fire  (cfg_fire),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .status    (status),
    .out_ready (out_tready),
    .out_valid (out_tvalid),
    .out_total (out_total),
    .out_count (out_count)
  );

  // result packing, total in the low bits
  assign out_tdata = OUT_DW'({out_count, out_total});

endmodule

`default_nettype wire

[sv/lwpd_ctrl.sv]
// ----------------------------------------------------------------------------
// lwpd_ctrl: sequencer of the landmark weighted distance unit
// Steps the datapath through squaring, square root, landmark tests,
// accumulation, held-pair flushes and result hand-off.
// ----------------------------------------------------------------------------
`default_nettype none

module lwpd_ctrl #(
  parameter int COORD_BITS = lwpd_pkg::COORD_BITS_DEF
) (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                in_fire,
  input  wire                in_op,
  output logic               in_ready,
  input  lwpd_pkg::status_t  status,
  output lwpd_pkg::cmd_t     cmd
);

  localparam int ROOT_STEPS = COORD_BITS + 2;
  localparam int CNT_W      = $clog2(ROOT_STEPS);
  localparam int SW         = lwpd_pkg::SLOT_W;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SQ,
    S_RINIT,
    S_ROOT,
    S_PLACE,
    S_WSEL,
    S_WA,
    S_WB,
    S_WC,
    S_PROD,
    S_ADD,
    S_CHECK,
    S_EMIT
  } state_t;

  state_t          state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [SW-1:0]   j_r, j_nxt;
  logic [SW-1:0]   k_r, k_nxt;
  logic [SW-1:0]   held_r, held_nxt;
  logic            flushing_r, flushing_nxt;
  logic            flush_last_r, flush_last_nxt;

  assign in_ready = (state_r == S_IDLE);

  // next state and commands
  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    j_nxt          = j_r;
    k_nxt          = k_r;
    held_nxt       = held_r;
    flushing_nxt   = flushing_r;
    flush_last_nxt = flush_last_r;
    cmd            = '0;
    cmd.lm         = j_r;
    cmd.idx        = k_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire && in_op == lwpd_pkg::OP_PAIR) begin
          state_nxt = S_SQ;
          cnt_nxt   = '0;
        end
      end
      S_SQ: begin
        cmd.sq_acc = 1'b1;
        cmd.axis   = lwpd_pkg::axis_t'(cnt_r[1:0]);
        if (cnt_r == CNT_W'(2)) begin
          state_nxt = S_RINIT;
          cnt_nxt   = '0;
        end else begin
          cnt_nxt = cnt_r + CNT_W'(1);
        end
      end
      S_RINIT: begin
        cmd.root_init = 1'b1;
        state_nxt     = S_ROOT;
      end
      S_ROOT: begin
        cmd.root_step = 1'b1;
        if (cnt_r == CNT_W'(ROOT_STEPS - 1)) begin
          state_nxt = S_PLACE;
        end else begin
          cnt_nxt = cnt_r + CNT_W'(1);
        end
      end
      S_PLACE: begin
        if (status.mode && held_r < SW'(lwpd_pkg::NUM_MARKS)) begin
          // self mode: this pair becomes a landmark and is held
          cmd.hold = 1'b1;
          cmd.idx  = held_r;
          held_nxt = held_r + SW'(1);
          if (held_r == SW'(lwpd_pkg::NUM_MARKS - 1)) begin
            flushing_nxt   = 1'b1;
            flush_last_nxt = 1'b0;
            k_nxt          = '0;
            state_nxt      = S_WSEL;
          end else begin
            state_nxt = S_CHECK;
          end
        end else begin
          cmd.load_direct = 1'b1;
          j_nxt           = '0;
          state_nxt       = S_WA;
        end
      end
      S_WSEL: begin
        cmd.load_held = 1'b1;
        j_nxt         = '0;
        state_nxt     = S_WA;
      end
      S_WA: begin
        cmd.w_a   = 1'b1;
        state_nxt = S_WB;
      end
      S_WB: begin
        cmd.w_b   = 1'b1;
        state_nxt = S_WC;
      end
      S_WC: begin
        cmd.w_c = 1'b1;
        if (j_r == lwpd_pkg::SLOT_JAW) begin
          state_nxt = S_PROD;
        end else begin
          j_nxt     = j_r + SW'(1);
          state_nxt = S_WA;
        end
      end
      S_PROD: begin
        cmd.prod  = 1'b1;
        state_nxt = S_ADD;
      end
      S_ADD: begin
        cmd.add = 1'b1;
        if (flushing_r) begin
          if (k_r + SW'(1) == held_r) begin
            flushing_nxt = 1'b0;
            state_nxt    = flush_last_r ? S_EMIT : S_CHECK;
          end else begin
            k_nxt     = k_r + SW'(1);
            state_nxt = S_WSEL;
          end
        end else begin
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (status.last) begin
          if (held_r != '0 && held_r < SW'(lwpd_pkg::NUM_MARKS)) begin
            // incomplete landmark set: flush what is held first
            flushing_nxt   = 1'b1;
            flush_last_nxt = 1'b1;
            k_nxt          = '0;
            state_nxt      = S_WSEL;
          end else begin
            state_nxt = S_EMIT;
          end
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_EMIT: begin
        if (status.out_free) begin
          cmd.emit       = 1'b1;
          held_nxt       = '0;
          flush_last_nxt = 1'b0;
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      cnt_r        <= '0;
      j_r          <= '0;
      k_r          <= '0;
      held_r       <= '0;
      flushing_r   <= 1'b0;
      flush_last_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      cnt_r        <= cnt_nxt;
      j_r          <= j_nxt;
      k_r          <= k_nxt;
      held_r       <= held_nxt;
      flushing_r   <= flushing_nxt;
      flush_last_r <= flush_last_nxt;
    end
  end

`ifndef ASSERT_OFF
  a_held_bound: assert property (@(posedge clk) disable iff (!rst_n)
    held_r <= SW'(lwpd_pkg::NUM_MARKS))
    else $error("held count above landmark count");
  a_flush_index: assert property (@(posedge clk) disable iff (!rst_n)
    flushing_r |-> k_r < held_r)
    else $error("flush index beyond held pairs");
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> status.out_free)
    else $error("result emitted over a pending one");
  a_emit_clears: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |=> held_r == '0 && !flushing_r)
    else $error("held pairs survive an emitted total");
`endif

endmodule

`default_nettype wire

[sv/lwpd_dp.sv]
// ----------------------------------------------------------------------------
// lwpd_dp: datapath of the landmark weighted distance unit
// Squared distance, bit-serial square root, landmark and held-pair storage,
// radius tests, weighted accumulation and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module lwpd_dp #(
  parameter int COORD_BITS = lwpd_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS  = lwpd_pkg::FRAC_BITS_DEF,
  parameter int COUNT_BITS = lwpd_pkg::COUNT_BITS_DEF
) (
  input  wire                                clk,
  input  wire                                rst_n,
  input  wire                                in_fire,
  input  wire                                in_op,
  input  wire  [lwpd_pkg::SLOT_W-1:0]        in_slot,
  input  wire  signed [COORD_BITS-1:0]       in_src_x,
  input  wire  signed [COORD_BITS-1:0]       in_src_y,
  input  wire  signed [COORD_BITS-1:0]       in_src_z,
  input  wire  signed [COORD_BITS-1:0]       in_tgt_x,
  input  wire  signed [COORD_BITS-1:0]       in_tgt_y,
  input  wire  signed [COORD_BITS-1:0]       in_tgt_z,
  input  wire                                in_last,
  input  wire                                cfg_fire,
  input  wire                                cfg_index,
  input  wire  [lwpd_pkg::BASE_W-1:0]        cfg_data,
  input  lwpd_pkg::cmd_t                     cmd,
  output lwpd_pkg::status_t                  status,
  input  wire                                out_ready,
  output logic                               out_valid,
  output logic [lwpd_pkg::TOTAL_W-1:0]       out_total,
  output logic [COUNT_BITS-1:0]              out_count
);

  localparam int DIFF_W  = COORD_BITS + 1;
  localparam int SQ_W    = 2 * DIFF_W;
  localparam int SUM_W   = SQ_W + 2;
  localparam int ROOT_W  = SUM_W / 2;
  localparam int REM_W   = ROOT_W + 2;
  localparam int DIST_W  = DIFF_W;
  localparam int EW      = ((COORD_BITS > FRAC_BITS + 6) ? COORD_BITS : FRAC_BITS + 6) + 4;
  localparam int LW      = FRAC_BITS + 4;
  localparam int LSQ_W   = 2 * LW + 1;
  localparam int WW      = lwpd_pkg::WEIGHT_W;
  localparam int TERM_W  = DIST_W + WW;
  localparam int TW      = lwpd_pkg::TOTAL_W;
  localparam int NM      = lwpd_pkg::NUM_MARKS;
  localparam int SW      = lwpd_pkg::SLOT_W;

  localparam logic signed [EW-1:0] OFF_X = EW'(25 * (1 << FRAC_BITS));
  localparam logic signed [EW-1:0] OFF_Y = EW'(30 * (1 << FRAC_BITS));
  localparam logic signed [EW-1:0] NOSE_DROP = EW'(10 * (1 << FRAC_BITS));

  // configuration
  logic                       mode_r;
  logic [lwpd_pkg::BASE_W-1:0] base_r;

  // captured item
  logic signed [COORD_BITS-1:0] sx_r, sy_r, sz_r, tx_r, ty_r, tz_r;
  logic                         last_r;

  // landmarks and held pairs
  logic signed [COORD_BITS-1:0] lx_r [NM];
  logic signed [COORD_BITS-1:0] ly_r [NM];
  logic signed [COORD_BITS-1:0] hx_r [NM];
  logic signed [COORD_BITS-1:0] hy_r [NM];
  logic [DIST_W-1:0]            hd_r [NM];

  // distance and root
  logic [SUM_W-1:0]  sum_r;
  logic [SUM_W-1:0]  rad_r;
  logic [REM_W-1:0]  rem_r;
  logic [ROOT_W-1:0] root_r;

  // weighting
  logic signed [EW-1:0] px_r, py_r;
  logic                 pself_r;
  logic [DIST_W-1:0]    dist_r;
  logic [LW-1:0]        dx_r, dy_r;
  logic                 far_r;
  logic [2*LW-1:0]      sqx_r;
  logic [WW-1:0]        w_r;
  logic [TERM_W-1:0]    term_r;

  // totals and result
  logic [TW-1:0]         total_r;
  logic [COUNT_BITS-1:0] tally_r;
  logic                  out_valid_r;
  logic [TW-1:0]         out_total_r;
  logic [COUNT_BITS-1:0] out_count_r;

  // per-axis squared difference
  logic signed [DIFF_W-1:0] diff_a, diff_b, diff;
  logic [DIFF_W-1:0]        dmag;
  logic [SQ_W-1:0]          dsq;
  logic [SUM_W-1:0]         sum_nxt;

  always_comb begin
    case (cmd.axis)
      lwpd_pkg::AXIS_X: begin
        diff_a = DIFF_W'(sx_r);
        diff_b = DIFF_W'(tx_r);
      end
      lwpd_pkg::AXIS_Y: begin
        diff_a = DIFF_W'(sy_r);
        diff_b = DIFF_W'(ty_r);
      end
      default: begin
        diff_a = DIFF_W'(sz_r);
        diff_b = DIFF_W'(tz_r);
      end
    endcase
    diff    = diff_a - diff_b;
    dmag    = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
    dsq     = dmag * dmag;
    sum_nxt = ((cmd.axis == lwpd_pkg::AXIS_X) ? '0 : sum_r) + SUM_W'(dsq);
  end

  // one root bit per step
  logic [REM_W-1:0] rem_sh, trial;
  logic             take;

  assign rem_sh = {rem_r[REM_W-3:0], rad_r[SUM_W-1 -: 2]};
  assign trial  = {root_r, 2'b01};
  assign take   = (rem_sh >= trial);

  // point selection
  logic signed [EW-1:0] sxe, sye, px_dir, py_dir;

  assign sxe    = EW'(sx_r);
  assign sye    = EW'(sy_r);
  assign px_dir = mode_r ? sxe : sxe + EW'(lx_r[lwpd_pkg::SLOT_NOSE]) - OFF_X;
  assign py_dir = mode_r ? sye : sye + EW'(ly_r[lwpd_pkg::SLOT_NOSE]) - OFF_Y;

  // radius test of one landmark
  logic [3:0]           rad;
  logic [EW-1:0]        lim;
  logic signed [EW-1:0] cx, cy, ddx, ddy;
  logic [EW-1:0]        adx, ady;
  logic [LSQ_W-1:0]     limsq, dist2;
  logic                 hit;

  always_comb begin
    rad   = lwpd_pkg::mark_radius(cmd.lm, pself_r);
    lim   = EW'(rad) << FRAC_BITS;
    cx    = EW'(lx_r[cmd.lm]);
    cy    = EW'(ly_r[cmd.lm]) - ((cmd.lm == lwpd_pkg::SLOT_NOSE) ? NOSE_DROP : '0);
    ddx   = px_r - cx;
    ddy   = py_r - cy;
    adx   = ddx[EW-1] ? EW'(-ddx) : EW'(ddx);
    ady   = ddy[EW-1] ? EW'(-ddy) : EW'(ddy);
    limsq = LSQ_W'(rad * rad) << (2 * FRAC_BITS);
    dist2 = LSQ_W'(sqx_r) + LSQ_W'(dy_r * dy_r);
    hit   = !far_r && (dist2 < limsq);
  end

  // saturating accumulation
  logic [TW:0] acc;

  assign acc = {1'b0, total_r} + (TW + 1)'(term_r);

  // configuration, landmarks, totals and handshake state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= 1'b0;
      base_r      <= '0;
      total_r     <= '0;
      tally_r     <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < NM; i++) begin
        lx_r[i] <= '0;
        ly_r[i] <= '0;
      end
    end else begin
      if (cfg_fire) begin
        unique case (cfg_index)
          lwpd_pkg::CFG_MODE: mode_r <= cfg_data[0];
          lwpd_pkg::CFG_BASE: base_r <= cfg_data;
          default: ;
        endcase
      end
      // landmark load transfer
      if (in_fire && in_op == lwpd_pkg::OP_LOAD && in_slot < SW'(NM)) begin
        lx_r[in_slot] <= in_src_x;
        ly_r[in_slot] <= in_src_y;
      end
      // self-mode pair becomes a landmark
      if (cmd.hold) begin
        lx_r[cmd.idx] <= sx_r;
        ly_r[cmd.idx] <= sy_r;
      end
      if (cmd.add) begin
        total_r <= acc[TW] ? {TW{1'b1}} : acc[TW-1:0];
        if (tally_r != {COUNT_BITS{1'b1}}) begin
          tally_r <= tally_r + COUNT_BITS'(1);
        end
      end
      if (cmd.emit) begin
        total_r     <= '0;
        tally_r     <= '0;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      sx_r   <= in_src_x;
      sy_r   <= in_src_y;
      sz_r   <= in_src_z;
      tx_r   <= in_tgt_x;
      ty_r   <= in_tgt_y;
      tz_r   <= in_tgt_z;
      last_r <= in_last;
    end
    if (cmd.sq_acc) begin
      sum_r <= sum_nxt;
    end
    if (cmd.root_init) begin
      rad_r  <= sum_r;
      rem_r  <= '0;
      root_r <= '0;
    end
    if (cmd.root_step) begin
      rad_r  <= rad_r << 2;
      rem_r  <= take ? rem_sh - trial : rem_sh;
      root_r <= {root_r[ROOT_W-2:0], take};
    end
    if (cmd.hold) begin
      hx_r[cmd.idx] <= sx_r;
      hy_r[cmd.idx] <= sy_r;
      hd_r[cmd.idx] <= root_r[DIST_W-1:0];
    end
    if (cmd.load_direct) begin
      px_r    <= px_dir;
      py_r    <= py_dir;
      pself_r <= mode_r;
      dist_r  <= root_r[DIST_W-1:0];
      w_r     <= WW'(base_r);
    end
    if (cmd.load_held) begin
      px_r    <= EW'(hx_r[cmd.idx]);
      py_r    <= EW'(hy_r[cmd.idx]);
      pself_r <= 1'b1;
      dist_r  <= hd_r[cmd.idx];
      w_r     <= WW'(base_r);
    end
    if (cmd.w_a) begin
      dx_r  <= adx[LW-1:0];
      dy_r  <= ady[LW-1:0];
      far_r <= (adx >= lim) || (ady >= lim);
    end
    if (cmd.w_b) begin
      sqx_r <= dx_r * dx_r;
    end
    if (cmd.w_c && hit) begin
      w_r <= w_r + WW'(lwpd_pkg::mark_bonus(cmd.lm));
    end
    if (cmd.prod) begin
      term_r <= dist_r * w_r;
    end
    if (cmd.emit) begin
      out_total_r <= total_r;
      out_count_r <= tally_r;
    end
  end

  assign status.mode     = mode_r;
  assign status.last     = last_r;
  assign status.out_free = !out_valid_r || out_ready;

  assign out_valid = out_valid_r;
  assign out_total = out_total_r;
  assign out_count = out_count_r;

endmodule

`default_nettype wire
